/* hw/rtl/hs_pkg.sv */
package hs_pkg;

   localparam int HS_DEPTH      = 64;
   localparam int HS_DATA_WIDTH = 32;
   localparam int HS_VALUE_W    = 32;

   typedef struct packed {
      logic swap;
      logic take_right;
   } hs_pick_type;

endpackage

/* hw/rtl/hs_ram.sv */
module hs_ram #(
   parameter int WIDTH = hs_pkg::HS_DATA_WIDTH,
   parameter int DEPTH = hs_pkg::HS_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

/* hw/rtl/hs_cmp.sv */
module hs_cmp #(
   parameter int WIDTH = hs_pkg::HS_DATA_WIDTH
) (
   input  logic [WIDTH-1:0]  cur,
   input  logic [WIDTH-1:0]  left,
   input  logic [WIDTH-1:0]  right,
   input  logic              left_ok,
   input  logic              right_ok,
   output hs_pkg::hs_pick_type pick
);
   import hs_pkg::*;

   logic left_gt_cur;
   logic right_gt_cur;
   logic right_gt_left;
   logic take_right;

   assign left_gt_cur   = $signed(left) > $signed(cur);
   assign right_gt_cur  = $signed(right) > $signed(cur);
   assign right_gt_left = $signed(right) > $signed(left);

   // The right child wins only when valid and strictly greater (signed) than the larger of the parent and left child.
   assign take_right = right_ok && ((left_ok && left_gt_cur) ? right_gt_left : right_gt_cur);

   assign pick.take_right = take_right;
   assign pick.swap       = take_right || (left_ok && left_gt_cur);

endmodule

/* hw/rtl/heap_sorter.sv */
// Loading: one word per cycle; busy stays low between words of a set.
// Sorting starts on the word marked last; each sift-down level reads both children
// from the element RAM (two read ports, one write port), compares them in the shared
// compare unit and writes the winner back to the parent slot.
// Results then follow one per cycle and cannot be stalled.
// Reset is synchronous: count, overflow flag, sequencer and strobe clear; the RAM does not.
module heap_sorter #(
   parameter int DEPTH      = hs_pkg::HS_DEPTH,
   parameter int DATA_WIDTH = hs_pkg::HS_DATA_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hs_pkg::HS_VALUE_W-1:0] req_value,
   input  logic                          req_last_item,
   output logic                          rsp_valid,
   output logic [hs_pkg::HS_VALUE_W-1:0] rsp_sorted_value,
   output logic                          rsp_last_result,
   output logic                          rsp_overflow
);
   import hs_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = IDX_W + 2;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_BUILD   = 3'd1;
   localparam logic [2:0] ST_FIRST   = 3'd2;
   localparam logic [2:0] ST_REQ     = 3'd3;
   localparam logic [2:0] ST_CMP     = 3'd4;
   localparam logic [2:0] ST_SWAP_RD = 3'd5;
   localparam logic [2:0] ST_SWAP_WR = 3'd6;
   localparam logic [2:0] ST_OUT     = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      at_ff, at_in;
   logic [CNT_W-1:0]      size_ff, size_in;
   logic                  extract_ff, extract_in;
   logic [DATA_WIDTH-1:0] cur_ff, cur_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]      rd_addr_a;
   logic [IDX_W-1:0]      rd_addr_b;
   logic [DATA_WIDTH-1:0] rd_data_a;
   logic [DATA_WIDTH-1:0] rd_data_b;

   logic [DATA_WIDTH-1:0] store_val;
   logic [CNT_W-1:0]      cnt_next;
   logic [CNT_W-1:0]      root;
   logic [CW-1:0]         left_w;
   logic [CW-1:0]         right_w;
   logic                  left_ok;
   logic                  right_ok;
   hs_pick_type           pick;
   logic [IDX_W-1:0]      child;
   logic [DATA_WIDTH-1:0] child_val;

   generate
      if (DATA_WIDTH <= HS_VALUE_W) begin : g_narrow
         assign store_val        = req_value[DATA_WIDTH-1:0];
         assign rsp_sorted_value = HS_VALUE_W'(rd_data_a);
      end else begin : g_wide
         assign store_val        = DATA_WIDTH'($signed(req_value));
         assign rsp_sorted_value = rd_data_a[HS_VALUE_W-1:0];
      end
   endgenerate

   hs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign left_w   = {1'b0, at_ff, 1'b1};
   assign right_w  = left_w + CW'(1);
   assign left_ok  = left_w < CW'(size_ff);
   assign right_ok = right_w < CW'(size_ff);

   hs_cmp #(.WIDTH(DATA_WIDTH)) u_cmp (
      .cur      (cur_ff),
      .left     (rd_data_a),
      .right    (rd_data_b),
      .left_ok  (left_ok),
      .right_ok (right_ok),
      .pick     (pick)
   );

   assign child     = pick.take_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
   assign child_val = pick.take_right ? rd_data_b : rd_data_a;
   assign cnt_next  = (count_ff < CNT_W'(DEPTH)) ? count_ff + CNT_W'(1) : count_ff;
   assign root      = idx_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      at_in        = at_ff;
      size_in      = size_ff;
      extract_in   = extract_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_ovf_in   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr_a    = '0;
      rd_addr_b    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[IDX_W-1:0];
                  wr_data = store_val;
               end else begin
                  dropped_in = 1'b1;
               end
               count_in = cnt_next;
               if (req_last_item) begin
                  idx_in     = cnt_next >> 1;
                  extract_in = 1'b0;
                  state_in   = ST_BUILD;
               end
            end
         end
         ST_BUILD: begin
            if (idx_ff == '0) begin
               if (count_ff <= CNT_W'(1)) begin
                  idx_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  idx_in     = count_ff - CNT_W'(1);
                  extract_in = 1'b1;
                  state_in   = ST_SWAP_RD;
               end
            end else begin
               rd_addr_a = root[IDX_W-1:0];
               at_in     = root[IDX_W-1:0];
               size_in   = count_ff;
               idx_in    = root;
               state_in  = ST_FIRST;
            end
         end
         ST_FIRST: begin
            cur_in    = rd_data_a;
            rd_addr_a = left_w[IDX_W-1:0];
            rd_addr_b = right_w[IDX_W-1:0];
            state_in  = ST_CMP;
         end
         ST_REQ: begin
            rd_addr_a = left_w[IDX_W-1:0];
            rd_addr_b = right_w[IDX_W-1:0];
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            wr_en   = 1'b1;
            wr_addr = at_ff;
            if (pick.swap) begin
               wr_data  = child_val;
               at_in    = child;
               state_in = ST_REQ;
            end else begin
               wr_data = cur_ff;
               if (!extract_ff) begin
                  state_in = ST_BUILD;
               end else if (idx_ff == CNT_W'(1)) begin
                  idx_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  idx_in   = idx_ff - CNT_W'(1);
                  state_in = ST_SWAP_RD;
               end
            end
         end
         ST_SWAP_RD: begin
            rd_addr_a = '0;
            rd_addr_b = idx_ff[IDX_W-1:0];
            state_in  = ST_SWAP_WR;
         end
         ST_SWAP_WR: begin
            wr_en     = 1'b1;
            wr_addr   = idx_ff[IDX_W-1:0];
            wr_data   = rd_data_a;
            cur_in    = rd_data_b;
            at_in     = '0;
            size_in   = idx_ff;
            rd_addr_a = IDX_W'(1);
            rd_addr_b = IDX_W'(2);
            state_in  = ST_CMP;
         end
         ST_OUT: begin
            rd_addr_a    = idx_ff[IDX_W-1:0];
            rsp_valid_in = 1'b1;
            rsp_ovf_in   = dropped_ff;
            if (idx_ff == count_ff - CNT_W'(1)) begin
               rsp_last_in = 1'b1;
               count_in    = '0;
               dropped_in  = 1'b0;
               state_in    = ST_IDLE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         idx_ff       <= '0;
         extract_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         rsp_ovf_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         idx_ff       <= idx_in;
         extract_ff   <= extract_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      at_ff   <= at_in;
      size_ff <= size_in;
      cur_ff  <= cur_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_last_result = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

/* hw/rtl/hs_chk.sv */
module hs_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_item,
   input logic rsp_valid,
   input logic rsp_last_result,
   input logic rsp_overflow
);

   a_word_no_stall: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last_item |=> !busy)
      else $error("block went busy on a word that is not last");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_item |=> busy)
      else $error("last word did not start the sort");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> rsp_valid && rsp_overflow == $past(rsp_overflow))
      else $error("sorted run broken or overflow changed within a run");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |=> !rsp_valid)
      else $error("result strobe after the final word of a run");

endmodule

bind heap_sorter hs_chk u_hs_chk (.*);
